### design/lpcs_pkg.sv
// Shared constants, codes and control types of the LPC all-pole synthesis filter.
package lpcs_pkg;

   localparam int LPCS_MAX_ORDER = 32;

   localparam int DATA_W  = 16;
   localparam int ORDER_W = 6;
   localparam int TAP_W   = 5;
   localparam int FUNC_W  = 2;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int COEF_FRAC = 12;

   localparam logic [FUNC_W-1:0] FN_FILTER = 2'd0;
   localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd16;

   localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_SUM,
      ST_EMIT
   } lpcs_state_type;

   typedef struct packed {
      logic issue;
      logic hist_ok;
      logic coef_ok;
      logic acc_clr;
      logic round_en;
      logic sum_en;
   } lpcs_mac_ctrl_type;

   typedef struct packed {
      logic pipe_busy;
   } lpcs_mac_stat_type;

endpackage

### design/lpcs_if.sv
// Request and response channel interfaces of the LPC synthesis filter.
interface lpcs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [lpcs_pkg::FUNC_W-1:0]    func;
   logic        [lpcs_pkg::TAP_W-1:0]     tap_index;
   logic signed [lpcs_pkg::DATA_W-1:0]    coef_value;
   logic signed [lpcs_pkg::DATA_W-1:0]    residual;

   modport source (output valid, func, tap_index, coef_value, residual, input ready);
   modport sink   (input valid, func, tap_index, coef_value, residual, output ready);
endinterface

interface lpcs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [lpcs_pkg::DATA_W-1:0] speech_sample;

   modport source (output valid, speech_sample, input ready);
   modport sink   (input valid, speech_sample, output ready);
endinterface

### design/lpcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module lpcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lpcs_mac.sv
// Shared multiply-accumulate datapath with rounding and output saturation.
module lpcs_mac #(
   parameter int MAX_ORDER = lpcs_pkg::LPCS_MAX_ORDER
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lpcs_pkg::lpcs_mac_ctrl_type          mac_ctrl,
   input  logic signed [lpcs_pkg::DATA_W-1:0]   residual,
   input  logic signed [lpcs_pkg::DATA_W-1:0]   hist_word,
   input  logic signed [lpcs_pkg::DATA_W-1:0]   coef_word,
   output lpcs_pkg::lpcs_mac_stat_type          mac_stat,
   output logic signed [lpcs_pkg::DATA_W-1:0]   sample
);

   localparam int ACC_W = lpcs_pkg::PROD_W + $clog2(MAX_ORDER) + 1;
   localparam int RND_W = ACC_W - lpcs_pkg::COEF_FRAC;
   localparam int SUM_W = RND_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (lpcs_pkg::COEF_FRAC - 1));

   logic                                s1_vld_ff, s1_hok_ff, s1_cok_ff;
   logic                                s2_vld_ff;
   logic signed [lpcs_pkg::DATA_W-1:0]  op_hist, op_coef;
   logic signed [lpcs_pkg::PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic signed [ACC_W-1:0]             acc_rnd;
   logic signed [RND_W-1:0]             rnd_ff;
   logic signed [SUM_W-1:0]             sum_v;
   logic signed [lpcs_pkg::DATA_W-1:0]  res_ff;
   logic signed [lpcs_pkg::DATA_W-1:0]  y_ff, y_in;

   // stage 1 flags line up with the registered RAM read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= mac_ctrl.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hok_ff <= mac_ctrl.hist_ok;
      s1_cok_ff <= mac_ctrl.coef_ok;
   end

   // history entries never written since reset or clear, and coefficients never written since reset, read as zero
   assign op_hist = s1_hok_ff ? hist_word : '0;
   assign op_coef = s1_cok_ff ? coef_word : '0;

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctrl.acc_clr) begin
         acc_in = '0;
      end else if (s2_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc_rnd = acc_ff + ROUND_HALF;
   assign sum_v   = SUM_W'(rnd_ff) + SUM_W'(res_ff);

   always_comb begin
      y_in = y_ff;
      if (mac_ctrl.sum_en) begin
         if (sum_v > SUM_W'(lpcs_pkg::SAMPLE_MAX)) begin
            y_in = lpcs_pkg::SAMPLE_MAX;
         end else if (sum_v < SUM_W'(lpcs_pkg::SAMPLE_MIN)) begin
            y_in = lpcs_pkg::SAMPLE_MIN;
         end else begin
            y_in = lpcs_pkg::DATA_W'(sum_v);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_hist * op_coef;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      if (mac_ctrl.acc_clr) begin
         res_ff <= residual;
      end
      if (mac_ctrl.round_en) begin
         // floor shift of the half-up biased sum
         rnd_ff <= $signed(acc_rnd[ACC_W-1:lpcs_pkg::COEF_FRAC]);
      end
   end

   assign mac_stat.pipe_busy = s1_vld_ff | s2_vld_ff;
   assign sample             = y_ff;

endmodule

### design/lpcs_seq.sv
// Sequencer: beat decode, tap loop, history pointers and entry-valid flags.
module lpcs_seq #(
   parameter int MAX_ORDER = lpcs_pkg::LPCS_MAX_ORDER,
   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
   localparam int OW = $clog2(MAX_ORDER + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   lpcs_req_if.sink                            req_chan,
   input  logic [lpcs_pkg::ORDER_W-1:0]        filter_order,
   input  logic                                out_free,
   input  lpcs_pkg::lpcs_mac_stat_type         mac_stat,
   output lpcs_pkg::lpcs_mac_ctrl_type         mac_ctrl,
   output logic                                emit,
   output logic                                hist_wr_en,
   output logic [AW-1:0]                       hist_wr_addr,
   output logic [AW-1:0]                       hist_rd_addr,
   output logic                                coef_wr_en,
   output logic [AW-1:0]                       coef_wr_addr,
   output logic [AW-1:0]                       coef_rd_addr
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ORDER - 1);

   lpcs_pkg::lpcs_state_type state_ff, state_in;

   logic [OW-1:0]        k_ff, k_in, ord_ff, ord_in, eff_ord, k_nxt;
   logic [AW-1:0]        rptr_ff, rptr_in, wp_ff, wp_in;
   logic [MAX_ORDER-1:0] hvld_ff, hvld_in, cvld_ff, cvld_in;
   logic                 accept, tap_ok, hist_clr;

   assign accept = req_chan.valid & req_chan.ready;
   assign tap_ok = 32'(req_chan.tap_index) < MAX_ORDER;
   assign k_nxt  = k_ff + OW'(1);

   always_comb begin
      if (32'(filter_order) > MAX_ORDER) begin
         eff_ord = OW'(MAX_ORDER);
      end else begin
         eff_ord = OW'(filter_order);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpcs_pkg::ST_IDLE: begin
            if (accept && req_chan.func == lpcs_pkg::FN_FILTER) begin
               state_in = (eff_ord == '0) ? lpcs_pkg::ST_DRAIN : lpcs_pkg::ST_RUN;
            end
         end
         lpcs_pkg::ST_RUN: begin
            if (k_nxt == ord_ff) begin
               state_in = lpcs_pkg::ST_DRAIN;
            end
         end
         lpcs_pkg::ST_DRAIN: begin
            if (!mac_stat.pipe_busy) begin
               state_in = lpcs_pkg::ST_ROUND;
            end
         end
         lpcs_pkg::ST_ROUND: state_in = lpcs_pkg::ST_SUM;
         lpcs_pkg::ST_SUM:   state_in = lpcs_pkg::ST_EMIT;
         lpcs_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = lpcs_pkg::ST_IDLE;
            end
         end
         default: state_in = lpcs_pkg::ST_IDLE;
      endcase
   end

   // outputs; ready is high throughout idle, so valid alone marks a beat there
   always_comb begin
      req_chan.ready = 1'b0;
      mac_ctrl       = '0;
      emit           = 1'b0;
      hist_wr_en     = 1'b0;
      coef_wr_en     = 1'b0;
      hist_clr       = 1'b0;
      unique case (state_ff)
         lpcs_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               unique case (req_chan.func)
                  lpcs_pkg::FN_FILTER: mac_ctrl.acc_clr = 1'b1;
                  lpcs_pkg::FN_LOAD:   coef_wr_en       = tap_ok;
                  lpcs_pkg::FN_CLEAR:  hist_clr         = 1'b1;
                  default: ;
               endcase
            end
         end
         lpcs_pkg::ST_RUN: begin
            mac_ctrl.issue   = 1'b1;
            mac_ctrl.hist_ok = hvld_ff[rptr_ff];
            mac_ctrl.coef_ok = cvld_ff[k_ff[AW-1:0]];
         end
         lpcs_pkg::ST_DRAIN: ;
         lpcs_pkg::ST_ROUND: mac_ctrl.round_en = 1'b1;
         lpcs_pkg::ST_SUM:   mac_ctrl.sum_en   = 1'b1;
         lpcs_pkg::ST_EMIT: begin
            emit       = out_free;
            hist_wr_en = out_free;
         end
         default: ;
      endcase
   end

   assign hist_wr_addr = wp_ff;
   assign hist_rd_addr = rptr_ff;
   assign coef_wr_addr = AW'(req_chan.tap_index);
   assign coef_rd_addr = k_ff[AW-1:0];

   // counters, pointers and valid flags
   always_comb begin
      k_in    = k_ff;
      ord_in  = ord_ff;
      rptr_in = rptr_ff;
      wp_in   = wp_ff;
      hvld_in = hvld_ff;
      cvld_in = cvld_ff;
      if (mac_ctrl.acc_clr) begin
         k_in    = '0;
         ord_in  = eff_ord;
         // newest sample sits just below the write pointer
         rptr_in = (wp_ff == '0) ? LAST_ADDR : wp_ff - AW'(1);
      end
      if (mac_ctrl.issue) begin
         k_in    = k_nxt;
         rptr_in = (rptr_ff == '0) ? LAST_ADDR : rptr_ff - AW'(1);
      end
      if (hist_clr) begin
         hvld_in = '0;
      end
      if (hist_wr_en) begin
         hvld_in[wp_ff] = 1'b1;
         wp_in          = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
      end
      if (coef_wr_en) begin
         cvld_in[coef_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpcs_pkg::ST_IDLE;
         wp_ff    <= '0;
         hvld_ff  <= '0;
         cvld_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         hvld_ff  <= hvld_in;
         cvld_ff  <= cvld_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ord_ff  <= ord_in;
      rptr_ff <= rptr_in;
   end

endmodule

### design/lpc_all_pole_synthesis_core.sv
// Top level of the LPC all-pole synthesis filter.
//
//   channel  dir  handshake        beat contents
//   req_     in   valid / ready    func, tap_index, coef_value, residual
//   rsp_     out  valid / ready    speech_sample (one per filter beat)
//   csr_     in   csr_wr_en        filter_order, 6 bits
//
// A filter beat: one shared 16x16 multiply-accumulate visits one tap a cycle (none at
// order zero), then drain, round and saturate. Load, clear and unused codes leave
// ready high; ready is low while a sample is in work. A finished sample waits in the
// response register while the next beat is taken; it is only stalled at the end if
// that register is still full. Reset clears history and coefficient valid flags at once.
module lpc_all_pole_synthesis_core #(
   parameter int MAX_ORDER = lpcs_pkg::LPCS_MAX_ORDER
) (
   input  logic                           clock,
   input  logic                           reset,
   lpcs_req_if.sink                       req_chan,
   lpcs_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [lpcs_pkg::ORDER_W-1:0]   csr_wr_data
);

   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   logic [lpcs_pkg::ORDER_W-1:0]        filter_order_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [lpcs_pkg::DATA_W-1:0]  rsp_data_ff;
   logic                                out_free, emit;
   logic                                hist_wr_en, coef_wr_en;
   logic [AW-1:0]                       hist_wr_addr, hist_rd_addr;
   logic [AW-1:0]                       coef_wr_addr, coef_rd_addr;
   logic signed [lpcs_pkg::DATA_W-1:0]  hist_word, coef_word, sample;
   lpcs_pkg::lpcs_mac_ctrl_type         mac_ctrl;
   lpcs_pkg::lpcs_mac_stat_type         mac_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff <= lpcs_pkg::ORDER_RESET;
      end else if (csr_wr_en) begin
         filter_order_ff <= csr_wr_data;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= sample;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.speech_sample = rsp_data_ff;

   lpcs_seq #(.MAX_ORDER(MAX_ORDER)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .filter_order (filter_order_ff),
      .out_free     (out_free),
      .mac_stat     (mac_stat),
      .mac_ctrl     (mac_ctrl),
      .emit         (emit),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_rd_addr (hist_rd_addr),
      .coef_wr_en   (coef_wr_en),
      .coef_wr_addr (coef_wr_addr),
      .coef_rd_addr (coef_rd_addr)
   );

   lpcs_ram #(.WIDTH(lpcs_pkg::DATA_W), .DEPTH(MAX_ORDER)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (sample),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_word)
   );

   lpcs_ram #(.WIDTH(lpcs_pkg::DATA_W), .DEPTH(MAX_ORDER)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (req_chan.coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_word)
   );

   lpcs_mac #(.MAX_ORDER(MAX_ORDER)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctrl  (mac_ctrl),
      .residual  (req_chan.residual),
      .hist_word (hist_word),
      .coef_word (coef_word),
      .mac_stat  (mac_stat),
      .sample    (sample)
   );

endmodule

### design/lpcs_checker.sv
// Port-level checker for the LPC synthesis filter, bound to the top level.
module lpcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [lpcs_pkg::FUNC_W-1:0]    req_func,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lpcs_pkg::DATA_W-1:0]    rsp_sample
);

   // a stalled response beat is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("response beat dropped or changed under stall");

   // ready drops straight after a filter beat is taken
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == lpcs_pkg::FN_FILTER |=> !req_ready)
      else $error("ready high straight after a filter beat");

   // ready stays high after a load, clear or unused code is taken
   a_other_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != lpcs_pkg::FN_FILTER |=> req_ready)
      else $error("ready dropped after a non-filter beat");

   // nothing is offered after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lpc_all_pole_synthesis_core lpcs_checker u_lpcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_func   (req_chan.func),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.speech_sample)
);

### test/tb_lpc_all_pole_synthesis_core.sv
// Self-checking testbench for the LPC all-pole synthesis filter core.
module tb_lpc_all_pole_synthesis_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lpcs_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
   localparam int N_DIRECTED     = 25;
   localparam int N_PHASES       = 10;
   localparam int RANDOM_PER_PHASE = 113;
   localparam int CFG_SETTLE     = 48;
   localparam int TAIL_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [lpcs_pkg::FUNC_W-1:0]        func;
      logic [lpcs_pkg::TAP_W-1:0]         tap;
      logic signed [lpcs_pkg::DATA_W-1:0] coef;
      logic signed [lpcs_pkg::DATA_W-1:0] resid;
   } lpcs_beat_type;

   typedef struct packed {
      bit                                 cfg;
      logic [lpcs_pkg::ORDER_W-1:0]       order;
      lpcs_beat_type                      beat;
      bit                                 typed;
      logic signed [lpcs_pkg::DATA_W-1:0] y;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [lpcs_pkg::ORDER_W-1:0] csr_wr_data;

   lpcs_req_if req_chan ();
   lpcs_rsp_if rsp_chan ();

   lpc_all_pole_synthesis_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // filter model state
   logic signed [lpcs_pkg::DATA_W-1:0] speech_history [lpcs_pkg::LPCS_MAX_ORDER];
   logic signed [lpcs_pkg::DATA_W-1:0] tap_coef [lpcs_pkg::LPCS_MAX_ORDER];
   logic [lpcs_pkg::ORDER_W-1:0]       model_order;
   logic signed [lpcs_pkg::DATA_W-1:0] speech_expected [$];

   int errors = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh7fff}, 1'b1, 16'sh7fff},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh8000}, 1'b1, 16'sh8000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b1, 16'sh0000},
      '{1'b0, 6'd0,  '{FN_UNUSED,           5'd31, 16'shffff, 16'shffff}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_LOAD,   5'd0,  16'sh1000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_LOAD,   5'd31, 16'sh8000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_LOAD,   5'd1,  16'sh7fff, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'shffff}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh7fff}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh8000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_CLEAR,  5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0005}, 1'b1, 16'sh0005},
      '{1'b1, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'shcfc7}, 1'b1, 16'shcfc7},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0001}, 1'b1, 16'sh0001},
      '{1'b1, 6'd63, '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh03e8}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_LOAD,   5'd31, 16'sh7fff, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'shfc18}, 1'b0, 16'sh0000},
      '{1'b1, 6'd32, '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_CLEAR,  5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b1, 6'd1,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh0000}, 1'b0, 16'sh0000},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh7fff}, 1'b1, 16'sh7fff},
      '{1'b0, 6'd0,  '{lpcs_pkg::FN_FILTER, 5'd0,  16'sh0000, 16'sh7fff}, 1'b0, 16'sh0000}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one beat to the model; returns 1 with the sample when one is produced.
   function automatic bit synth_step(input lpcs_beat_type b,
                                     output logic signed [lpcs_pkg::DATA_W-1:0] y);
      longint acc;
      longint sum;
      int     taps;
      y = '0;
      case (b.func)
         lpcs_pkg::FN_FILTER: begin
            acc  = 0;
            taps = (model_order > lpcs_pkg::LPCS_MAX_ORDER) ? lpcs_pkg::LPCS_MAX_ORDER
                                                            : int'(model_order);
            for (int j = 0; j < taps; j++)
               acc += longint'(tap_coef[j]) * longint'(speech_history[j]);
            // round half up, floor shift
            sum = ((acc + 2048) >>> lpcs_pkg::COEF_FRAC) + longint'(b.resid);
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            y = sum[lpcs_pkg::DATA_W-1:0];
            for (int j = lpcs_pkg::LPCS_MAX_ORDER - 1; j > 0; j--)
               speech_history[j] = speech_history[j-1];
            speech_history[0] = y;
            return 1'b1;
         end
         lpcs_pkg::FN_LOAD: begin
            tap_coef[b.tap] = b.coef;
         end
         lpcs_pkg::FN_CLEAR: begin
            for (int j = 0; j < lpcs_pkg::LPCS_MAX_ORDER; j++)
               speech_history[j] = '0;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic lpcs_beat_type random_beat();
      lpcs_beat_type b;
      int pick;
      int v;
      pick    = $urandom_range(0, 99);
      b.func  = (pick < 70) ? lpcs_pkg::FN_FILTER : (pick < 90) ? lpcs_pkg::FN_LOAD :
                (pick < 96) ? lpcs_pkg::FN_CLEAR : FN_UNUSED;
      b.tap   = lpcs_pkg::TAP_W'($urandom_range(0, lpcs_pkg::LPCS_MAX_ORDER - 1));
      v       = ($urandom_range(0, 99) < 15) ? int'($urandom)
                                             : int'($urandom_range(0, 1023)) - 512;
      b.coef  = v[lpcs_pkg::DATA_W-1:0];
      v       = ($urandom_range(0, 99) < 40) ? int'($urandom)
                                             : int'($urandom_range(0, 4000)) - 2000;
      b.resid = v[lpcs_pkg::DATA_W-1:0];
      return b;
   endfunction

   task automatic send_beat(input lpcs_beat_type b, input bit typed,
                            input logic signed [lpcs_pkg::DATA_W-1:0] typed_y);
      logic signed [lpcs_pkg::DATA_W-1:0] y;
      req_chan.valid      <= 1'b1;
      req_chan.func       <= b.func;
      req_chan.tap_index  <= b.tap;
      req_chan.coef_value <= b.coef;
      req_chan.residual   <= b.resid;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (synth_step(b, y))
         speech_expected.push_back(typed ? typed_y : y);
   endtask

   // bursts of beats with random gaps between them
   task automatic pace();
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (speech_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_order(input logic [lpcs_pkg::ORDER_W-1:0] v);
      wait_drained();
      // a trailing load or clear leaves no result to wait for
      repeat (CFG_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_order = v;
   endtask

   // stimulus
   initial begin
      int phase_orders [N_PHASES];
      lpcs_beat_type b;
      int v;
      phase_orders = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd33, 6'd2, 6'd5, 6'd16, 6'd0, 6'd0};
      model_order = lpcs_pkg::ORDER_RESET;
      for (int j = 0; j < lpcs_pkg::LPCS_MAX_ORDER; j++) begin
         speech_history[j] = '0;
         tap_coef[j]       = '0;
      end
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= lpcs_pkg::FN_FILTER;
      req_chan.tap_index  <= '0;
      req_chan.coef_value <= '0;
      req_chan.residual   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg) begin
            write_order(directed_rows[i].order);
         end else begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].y);
            pace();
         end
      end

      phase_orders[8] = $urandom_range(0, 63);
      phase_orders[9] = $urandom_range(0, 63);
      for (int p = 0; p < N_PHASES; p++) begin
         write_order(phase_orders[p][lpcs_pkg::ORDER_W-1:0]);
         // fresh coefficient set, taps further out kept smaller
         for (int t = 0; t < lpcs_pkg::LPCS_MAX_ORDER; t++) begin
            v       = int'($urandom_range(0, (4096 >> (t / 4)))) - (2048 >> (t / 4));
            b.func  = lpcs_pkg::FN_LOAD;
            b.tap   = lpcs_pkg::TAP_W'(t);
            b.coef  = v[lpcs_pkg::DATA_W-1:0];
            b.resid = lpcs_pkg::DATA_W'($urandom);
            send_beat(b, 1'b0, '0);
            pace();
         end
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (k == RANDOM_PER_PHASE / 2)
               wait_drained();
            send_beat(random_beat(), 1'b0, '0);
            pace();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls in windows of differing density
   initial begin
      int mode;
      int window;
      mode   = 0;
      window = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            mode   = $urandom_range(0, 3);
            window = $urandom_range(16, 96);
         end
         window--;
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= ~rsp_chan.ready;
         endcase
      end
   end

   always @(posedge clock) begin
      logic signed [lpcs_pkg::DATA_W-1:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (speech_expected.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: expected none, got %0d", $time,
                     rsp_chan.speech_sample);
         end else begin
            want = speech_expected.pop_front();
            if (rsp_chan.speech_sample !== want) begin
               errors++;
               $display("%0t speech_sample mismatch: expected %0d, got %0d", $time,
                        want, rsp_chan.speech_sample);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### files.f
design/lpcs_pkg.sv
design/lpcs_if.sv
design/lpcs_ram.sv
design/lpcs_mac.sv
design/lpcs_seq.sv
design/lpc_all_pole_synthesis_core.sv
design/lpcs_checker.sv
test/tb_lpc_all_pole_synthesis_core.sv
